[sv/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and codes for the first-fit page bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

   localparam int ADDR_W     = 48;
   localparam int CNT_W      = 11;
   localparam int STAT_W     = 3;
   localparam int WORD_BITS  = 64;
   localparam int WORD_SHIFT = 6;
   localparam int CSR_AW     = 4;
   localparam int CSR_DW     = 64;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic REG_BASE  = 1'b0;
   localparam logic REG_PAGES = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_BAD_CNT  = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_RUN   = 3'd2;
   localparam logic [STAT_W-1:0] ST_BAD_ADDR = 3'd3;
   localparam logic [STAT_W-1:0] ST_PAST_END = 3'd4;

   typedef struct packed {
      logic              opcode;
      logic [CNT_W-1:0]  pg_cnt;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] result_addr;
      logic [CNT_W-1:0]  free_cnt;
      logic [CNT_W-1:0]  used_cnt;
   } rsp_type;

   typedef struct packed {
      logic              load;
      logic              clr_init;
      logic              clr_wr;
      logic              scan_init;
      logic              scan_step;
      logic              div_init;
      logic              div_step;
      logic              mark_init_alloc;
      logic              mark_init_free;
      logic              rd_mark;
      logic              mark_wr;
      logic              set_stat;
      logic [STAT_W-1:0] stat;
      logic              upd;
      logic              done;
   } cmd_type;

   typedef struct packed {
      logic clr_pend;
      logic clr_last;
      logic op;
      logic bad_count;
      logic bad_addr;
      logic div_last;
      logic past_end;
      logic zero_n;
      logic hit;
      logic scan_last;
      logic mark_last;
   } sts_type;

endpackage

`default_nettype wire

[sv/first_fit_page_bitmap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator_core
// First-fit page allocator over a used/free bitmap with page counters.
// ----------------------------------------------------------------------------
// Usage: drive req_data and pulse start while busy is low; the request is
// taken at that edge. Exactly one response follows: rsp_valid is high for
// one cycle with rsp_data (status, result_addr, free/used counts). The
// receiver cannot stall, so capture the response in that cycle.
// Registers on the APB port: base_addr at 0x0, managed_pages at 0x8.
// Writing managed_pages resets the counts and starts a clear sweep.
// The bitmap lives in a RAM of 64-page words with registered read.
// An allocate scans words for the first free run, then marks the words of
// the run; a rejected allocate goes straight to the response. A free
// takes its page index from a reciprocal multiply of the offset, then
// clears the words of the run. A free with a bad address is rejected at once.
// One request is in flight at a time.
// Reset: synchronous; after reset, and after each managed_pages write, a
// clear sweep over all ceil(NUM_PAGES/64) bitmap words runs with busy high
// (after a write, it starts once the controller is back in idle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_page_bitmap_allocator_core #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire ffpa_pkg::req_type             req_data,
   output logic                               rsp_valid,
   output ffpa_pkg::rsp_type                  rsp_data,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ffpa_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [ffpa_pkg::CSR_DW-1:0]   pwdata,
   output logic      [ffpa_pkg::CSR_DW-1:0]   prdata,
   output logic                               pready
);

   ffpa_pkg::cmd_type cmd;
   ffpa_pkg::sts_type sts;

   assign pready = 1'b1;

   ffpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   ffpa_dp #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while response is presented");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ffpa_pkg::ST_OK)) |-> (rsp_data.result_addr == '0))
      else $error("failed request returned an address");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("response too soon after request");

endmodule

`default_nettype wire

[sv/ffpa_ram.sv]
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [WIDTH-1:0]    wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output logic      [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/ffpa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer for clear sweep, bitmap scan, address divide and run marking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ffpa_pkg::sts_type sts,
   output logic                   busy,
   output ffpa_pkg::cmd_type      cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SRD   = 4'd3;
   localparam logic [3:0] S_SEV   = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_RANGE = 4'd6;
   localparam logic [3:0] S_MRD   = 4'd7;
   localparam logic [3:0] S_MWR   = 4'd8;
   localparam logic [3:0] S_UPD   = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_pend) begin
               cmd.clr_init = 1'b1;
            end else begin
               cmd.clr_wr = 1'b1;
               if (sts.clr_last) state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (sts.clr_pend) begin
               cmd.clr_init = 1'b1;
               state_in     = S_CLEAR;
            end else if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.op == ffpa_pkg::OP_ALLOC) begin
               if (sts.bad_count) begin
                  cmd.set_stat = 1'b1;
                  cmd.stat     = ffpa_pkg::ST_BAD_CNT;
                  state_in     = S_DONE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_SRD;
               end
            end else begin
               if (sts.bad_addr) begin
                  cmd.set_stat = 1'b1;
                  cmd.stat     = ffpa_pkg::ST_BAD_ADDR;
                  state_in     = S_DONE;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = S_DIV;
               end
            end
         end
         S_SRD: state_in = S_SEV;
         S_SEV: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.mark_init_alloc = 1'b1;
               state_in            = S_MRD;
            end else if (sts.scan_last) begin
               cmd.set_stat = 1'b1;
               cmd.stat     = ffpa_pkg::ST_NO_RUN;
               state_in     = S_DONE;
            end else begin
               state_in = S_SRD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_RANGE;
         end
         S_RANGE: begin
            if (sts.past_end) begin
               cmd.set_stat = 1'b1;
               cmd.stat     = ffpa_pkg::ST_PAST_END;
               state_in     = S_DONE;
            end else if (sts.zero_n) begin
               state_in = S_UPD;
            end else begin
               cmd.mark_init_free = 1'b1;
               state_in           = S_MRD;
            end
         end
         S_MRD: begin
            cmd.rd_mark = 1'b1;
            state_in    = S_MWR;
         end
         S_MWR: begin
            cmd.rd_mark = 1'b1;
            cmd.mark_wr = 1'b1;
            state_in    = sts.mark_last ? S_UPD : S_MRD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a pending clear sweep holds off new requests
   assign busy = (state_ff != S_IDLE) | sts.clr_pend;

endmodule

`default_nettype wire

[sv/ffpa_dp.sv]
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: registers, bitmap RAM, word scan, page index divider, counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffpa_dp #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ffpa_pkg::req_type               req_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ffpa_pkg::CSR_AW-1:0]     paddr,
   input  wire logic [ffpa_pkg::CSR_DW-1:0]     pwdata,
   output logic      [ffpa_pkg::CSR_DW-1:0]     prdata,
   input  wire ffpa_pkg::cmd_type               cmd,
   output ffpa_pkg::sts_type                    sts,
   output logic                                 rsp_valid,
   output ffpa_pkg::rsp_type                    rsp_data
);

   localparam int WB    = ffpa_pkg::WORD_BITS;
   localparam int WS    = ffpa_pkg::WORD_SHIFT;
   localparam int CW    = ffpa_pkg::CNT_W;
   localparam int AW    = ffpa_pkg::ADDR_W;
   localparam int NW    = (NUM_PAGES + WB - 1) / WB;
   localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
   localparam int IWC   = $clog2(NUM_PAGES + WB);
   localparam int IW    = (IWC > 12) ? IWC : 12;
   localparam int PBW   = $clog2(PAGE_BYTES + 1);
   localparam int SW    = CW + PBW;
   localparam int QCW   = $clog2(CW);
   localparam int MP_RST = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;
   // page index = (offset * RM) >> RS, exact for every offset below 2**SW
   localparam int PBL   = $clog2(PAGE_BYTES);
   localparam int RS    = SW + PBL;
   localparam longint unsigned RM = ((64'd1 << RS) + 64'(PAGE_BYTES) - 64'd1) /
                                    64'(PAGE_BYTES);
   localparam logic [SW:0] RM_C = (SW+1)'(RM);

   logic [AW-1:0]  base_ff;
   logic [CW-1:0]  pages_ff;
   logic [SW-1:0]  span_ff;
   logic           clr_pend_ff;
   logic [WAW-1:0] clr_ptr_ff;
   logic           op_ff;
   logic [CW-1:0]  n_ff;
   logic [AW-1:0]  addr_ff;
   logic [CW-1:0]  free_ff, used_ff;
   logic [WAW-1:0] sw_ff, mw_ff;
   logic [IW-1:0]  rs_ff, lo_ff;
   logic [IW:0]    hi_ff;
   logic [SW-1:0]  rem_ff;
   logic [2*SW:0]  dprod_ff;
   logic [CW-1:0]  q_ff;
   logic [QCW-1:0] dcnt_ff;
   logic [2:0]     stat_ff;
   logic [AW-1:0]  prod_ff;
   logic           rsp_valid_ff;
   ffpa_pkg::rsp_type rsp_ff;

   logic           csr_wr;
   logic [CW-1:0]  wr_pages;
   logic [WB-1:0]  rd_word, new_word;
   logic [WAW-1:0] ram_waddr, ram_raddr;
   logic [WB-1:0]  ram_wdata;
   logic           ram_we;

   // scan and mark combinational results
   logic [IW-1:0]  scan_start, scan_rs;
   logic           scan_hit;
   logic [IW:0]    sbase, mbase;
   logic [CW:0]    usum, fsum;

   assign csr_wr = psel & penable & pwrite;
   assign wr_pages = (32'(pwdata[CW-1:0]) > 32'(NUM_PAGES)) ? CW'(NUM_PAGES) : pwdata[CW-1:0];
   assign prdata = (paddr[3] == ffpa_pkg::REG_BASE) ?
                   {{(ffpa_pkg::CSR_DW-AW){1'b0}}, base_ff} :
                   {{(ffpa_pkg::CSR_DW-CW){1'b0}}, pages_ff};

   assign ram_raddr = cmd.rd_mark ? mw_ff : sw_ff;
   assign ram_we    = cmd.clr_wr | cmd.mark_wr;
   assign ram_waddr = cmd.clr_wr ? clr_ptr_ff : mw_ff;
   assign ram_wdata = cmd.clr_wr ? '0 : new_word;

   ffpa_ram #(.WIDTH(WB), .DEPTH(NW)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_word)
   );

   // Word scan: pages past the managed count act as used, so runs stop there.
   always_comb begin
      logic [IW:0]   p;
      logic [IW-1:0] st;
      logic          found;
      logic [IW-1:0] fst;
      sbase = (IW+1)'(sw_ff) << WS;
      st    = rs_ff;
      found = 1'b0;
      fst   = '0;
      for (int j = 0; j < WB; j++) begin
         p = sbase + (IW+1)'(j);
         if (rd_word[j] || (p >= (IW+1)'(pages_ff))) begin
            st = IW'(p + 1'b1);
         end else if (!found &&
                      ((p + 1'b1) >= ((IW+1)'(st) + (IW+1)'(n_ff)))) begin
            found = 1'b1;
            fst   = st;
         end
      end
      scan_rs    = st;
      scan_hit   = found;
      scan_start = fst;
   end

   always_comb begin
      logic [IW:0] p;
      mbase = (IW+1)'(mw_ff) << WS;
      for (int j = 0; j < WB; j++) begin
         p = mbase + (IW+1)'(j);
         if ((p >= (IW+1)'(lo_ff)) && (p < hi_ff)) begin
            new_word[j] = (op_ff == ffpa_pkg::OP_ALLOC);
         end else begin
            new_word[j] = rd_word[j];
         end
      end
   end

   assign usum = (CW+1)'(used_ff) + (CW+1)'(n_ff);
   assign fsum = (CW+1)'(free_ff) + (CW+1)'(n_ff);

   always_comb begin
      sts           = '0;
      sts.clr_pend  = clr_pend_ff;
      sts.clr_last  = (clr_ptr_ff == WAW'(NW - 1));
      sts.op        = op_ff;
      sts.bad_count = (n_ff == '0) || (n_ff > free_ff);
      sts.bad_addr  = ({1'b0, addr_ff} < {1'b0, base_ff}) ||
                      ({1'b0, addr_ff} >= ({1'b0, base_ff} + (AW+1)'(span_ff)));
      sts.div_last  = (dcnt_ff == '0);
      sts.past_end  = ((CW+1)'(q_ff) + (CW+1)'(n_ff)) > (CW+1)'(pages_ff);
      sts.zero_n    = (n_ff == '0);
      sts.hit       = scan_hit;
      sts.scan_last = (sbase + (IW+1)'(WB)) >= (IW+1)'(pages_ff);
      sts.mark_last = (mbase + (IW+1)'(WB)) >= hi_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         pages_ff     <= CW'(MP_RST);
         free_ff      <= CW'(MP_RST);
         used_ff      <= '0;
         clr_pend_ff  <= 1'b0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.done;
         if (cmd.clr_init) begin
            clr_pend_ff <= 1'b0;
            clr_ptr_ff  <= '0;
         end else if (cmd.clr_wr) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (cmd.upd) begin
            if (op_ff == ffpa_pkg::OP_ALLOC) begin
               free_ff <= free_ff - n_ff;
               used_ff <= (usum > (CW+1)'(pages_ff)) ? pages_ff : usum[CW-1:0];
            end else begin
               free_ff <= (fsum > (CW+1)'(pages_ff)) ? pages_ff : fsum[CW-1:0];
               used_ff <= (used_ff >= n_ff) ? (used_ff - n_ff) : '0;
            end
         end
         if (csr_wr) begin
            if (paddr[3] == ffpa_pkg::REG_BASE) begin
               base_ff <= pwdata[AW-1:0];
            end else begin
               pages_ff    <= wr_pages;
               free_ff     <= wr_pages;
               used_ff     <= '0;
               clr_pend_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      span_ff <= SW'(pages_ff) * SW'(PAGE_BYTES);
      if (cmd.load) begin
         op_ff   <= req_data.opcode;
         n_ff    <= req_data.pg_cnt;
         addr_ff <= req_data.address;
         stat_ff <= ffpa_pkg::ST_OK;
      end
      if (cmd.set_stat) stat_ff <= cmd.stat;
      if (cmd.scan_init) begin
         sw_ff <= '0;
         rs_ff <= '0;
      end else if (cmd.scan_step) begin
         sw_ff <= sw_ff + 1'b1;
         rs_ff <= scan_rs;
      end
      // two steps: reciprocal product, then its high part as the page index
      if (cmd.div_init) begin
         rem_ff  <= SW'(addr_ff - base_ff);
         q_ff    <= '0;
         dcnt_ff <= QCW'(1);
      end else if (cmd.div_step) begin
         if (dcnt_ff != '0) begin
            dprod_ff <= (2*SW+1)'(rem_ff) * (2*SW+1)'(RM_C);
         end else begin
            q_ff <= dprod_ff[RS +: CW];
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.mark_init_alloc) begin
         lo_ff <= scan_start;
         hi_ff <= (IW+1)'(scan_start) + (IW+1)'(n_ff);
         mw_ff <= WAW'(scan_start >> WS);
      end else if (cmd.mark_init_free) begin
         lo_ff <= IW'(q_ff);
         hi_ff <= (IW+1)'(q_ff) + (IW+1)'(n_ff);
         mw_ff <= WAW'(q_ff >> WS);
      end else if (cmd.mark_wr) begin
         mw_ff <= mw_ff + 1'b1;
      end
      if (cmd.upd) begin
         prod_ff <= AW'((IW+PBW)'(lo_ff) * (IW+PBW)'(PAGE_BYTES));
      end
      if (cmd.done) begin
         rsp_ff.status      <= stat_ff;
         rsp_ff.result_addr <= ((stat_ff == ffpa_pkg::ST_OK) &&
                                (op_ff == ffpa_pkg::OP_ALLOC)) ? (base_ff + prod_ff) : '0;
         rsp_ff.free_cnt    <= free_ff;
         rsp_ff.used_cnt    <= used_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[dv/first_fit_page_bitmap_allocator_core_checker.sv]
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator_core_checker
// Watches the request, response and register ports of the allocator, keeps a
// shadow bitmap with page counters, and compares every response field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_page_bitmap_allocator_core_checker #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  ffpa_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  ffpa_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ffpa_pkg::CSR_AW-1:0]     paddr,
   input  logic [ffpa_pkg::CSR_DW-1:0]     pwdata,
   input  logic                            pready,
   output int                              errors,
   output int                              pending
);

   localparam int MP_RST = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;

   logic                        page_used [NUM_PAGES];
   logic [ffpa_pkg::ADDR_W-1:0] base_addr;
   int                          page_limit;
   int                          free_total;
   int                          used_total;
   ffpa_pkg::rsp_type           expected_rsps [$];

   task automatic clear_pages();
      for (int i = 0; i < NUM_PAGES; i++) page_used[i] = 1'b0;
      free_total = page_limit;
      used_total = 0;
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: response %s mismatch: got 0x%0h expected 0x%0h", $time, field, got, want);
      errors++;
   endtask

   // First-fit allocate or range-checked free against the shadow bitmap.
   task automatic apply_request(input ffpa_pkg::req_type r, output ffpa_pkg::rsp_type o);
      int          n;
      int          run;
      int          first;
      int          found;
      logic [63:0] region_end;
      logic [63:0] idx;
      n = int'(r.pg_cnt);
      o = '0;
      if (r.opcode == ffpa_pkg::OP_ALLOC) begin
         found = -1;
         if (n == 0 || n > free_total) begin
            o.status = ffpa_pkg::ST_BAD_CNT;
         end else begin
            run = 0;
            first = 0;
            for (int i = 0; i < page_limit && found < 0; i++) begin
               if (!page_used[i]) begin
                  if (run == 0) first = i;
                  run++;
                  if (run == n) found = first;
               end else begin
                  run = 0;
               end
            end
            if (found < 0) begin
               o.status = ffpa_pkg::ST_NO_RUN;
            end else begin
               for (int i = found; i < found + n; i++) page_used[i] = 1'b1;
               o.result_addr = base_addr + ffpa_pkg::ADDR_W'(found) *
                               ffpa_pkg::ADDR_W'(PAGE_BYTES);
               free_total -= n;
               used_total += n;
               if (used_total > page_limit) used_total = page_limit;
            end
         end
      end else begin
         region_end = 64'(base_addr) + 64'(page_limit) * 64'(PAGE_BYTES);
         if (r.address < base_addr || 64'(r.address) >= region_end) begin
            o.status = ffpa_pkg::ST_BAD_ADDR;
         end else begin
            idx = 64'(r.address - base_addr) / 64'(PAGE_BYTES);
            if (idx + 64'(n) > 64'(page_limit)) begin
               o.status = ffpa_pkg::ST_PAST_END;
            end else begin
               for (int i = int'(idx); i < int'(idx) + n; i++) page_used[i] = 1'b0;
               free_total += n;
               if (free_total > page_limit) free_total = page_limit;
               used_total = (used_total >= n) ? used_total - n : 0;
            end
         end
      end
      o.free_cnt = ffpa_pkg::CNT_W'(free_total);
      o.used_cnt = ffpa_pkg::CNT_W'(used_total);
   endtask

   always @(posedge clock) begin
      ffpa_pkg::rsp_type want;
      ffpa_pkg::rsp_type got;
      if (reset) begin
         base_addr = '0;
         page_limit = MP_RST;
         clear_pages();
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_rsps.size() == 0) begin
               report("strobe", 64'd1, 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status)
                  report("status", 64'(got.status), 64'(want.status));
               if (got.result_addr !== want.result_addr)
                  report("result_addr", 64'(got.result_addr), 64'(want.result_addr));
               if (got.free_cnt !== want.free_cnt)
                  report("free_cnt", 64'(got.free_cnt), 64'(want.free_cnt));
               if (got.used_cnt !== want.used_cnt)
                  report("used_cnt", 64'(got.used_cnt), 64'(want.used_cnt));
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[3] == ffpa_pkg::REG_BASE) begin
               base_addr = pwdata[ffpa_pkg::ADDR_W-1:0];
            end else begin
               page_limit = int'(pwdata[ffpa_pkg::CNT_W-1:0]);
               if (page_limit > NUM_PAGES) page_limit = NUM_PAGES;
               clear_pages();
            end
         end
         if (start && !busy) begin
            apply_request(req_data, want);
            expected_rsps.push_back(want);
         end
      end
      pending = expected_rsps.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

[dv/first_fit_page_bitmap_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_page_bitmap_allocator_core_tb
// Drives directed and random allocate/free requests through several
// base-address and page-count settings; the checker judges each response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_page_bitmap_allocator_core_tb;

   localparam int NUM_PAGES  = 1024;
   localparam int PAGE_BYTES = 4096;
   localparam int STALL_LIMIT = 4000;
   localparam int AW = ffpa_pkg::ADDR_W;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   ffpa_pkg::req_type             req_data;
   logic                          rsp_valid;
   ffpa_pkg::rsp_type             rsp_data;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [ffpa_pkg::CSR_AW-1:0]   paddr;
   logic [ffpa_pkg::CSR_DW-1:0]   pwdata;
   logic [ffpa_pkg::CSR_DW-1:0]   prdata;
   logic                          pready;
   int                            errors;
   int                            pending;
   int                            idle_count;
   logic [AW-1:0]                 cur_base;
   int                            cur_pages;
   bit                            gaps_on;

   always #4 clock = ~clock;

   first_fit_page_bitmap_allocator_core #(
      .NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)
   ) dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   first_fit_page_bitmap_allocator_core_checker #(
      .NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)
   ) chk (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
   );

   // watchdog: cycles in which nothing moves on any port
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Leaves start high at the accepting edge so requests can go back to back.
   task automatic send(logic op, int n, logic [AW-1:0] a);
      ffpa_pkg::req_type r;
      r.opcode = op;
      r.pg_cnt = ffpa_pkg::CNT_W'(n);
      r.address = a;
      if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 17));
      start <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain();
      idle_cycles(1);
      while (pending != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [63:0] value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_sel == ffpa_pkg::REG_BASE) begin
         cur_base = value[AW-1:0];
      end else begin
         cur_pages = int'(value[ffpa_pkg::CNT_W-1:0]);
         if (cur_pages > NUM_PAGES) cur_pages = NUM_PAGES;
      end
   endtask

   function automatic logic [AW-1:0] page_addr(int idx);
      return cur_base + AW'(idx) * AW'(PAGE_BYTES)
             + AW'($urandom_range(0, PAGE_BYTES - 1));
   endfunction

   function automatic logic [AW-1:0] rand_addr();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   // Mostly small allocates and in-range frees; some noise and big sizes.
   task automatic random_requests(int count);
      int sel;
      int n;
      int idx;
      int span;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         span = (cur_pages > 0) ? cur_pages : 1;
         if (sel < 45) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : $urandom_range(1, 8);
            send(ffpa_pkg::OP_ALLOC, n, rand_addr());
         end else if (sel < 85) begin
            idx = $urandom_range(0, span - 1);
            n = $urandom_range(0, 8);
            if (idx + n > cur_pages) n = cur_pages - idx;
            if (n < 0) n = 0;
            send(ffpa_pkg::OP_FREE, n, page_addr(idx));
         end else if (sel < 92) begin
            send(ffpa_pkg::OP_FREE, $urandom_range(0, 2047), rand_addr());
         end else if (sel < 96) begin
            send(1'($urandom_range(0, 1)), $urandom_range(0, 2047), rand_addr());
         end else begin
            idx = $urandom_range(0, span - 1);
            send(ffpa_pkg::OP_FREE, $urandom_range(span - idx, span - idx + 20),
                 page_addr(idx));
         end
         if ($urandom_range(0, 199) == 0) drain();
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      idle_count <= 0;
      cur_base = '0;
      cur_pages = NUM_PAGES;
      gaps_on = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: default setting, counts at the edges
      send(ffpa_pkg::OP_ALLOC, 0, '0);
      send(ffpa_pkg::OP_ALLOC, 2047, '0);
      send(ffpa_pkg::OP_ALLOC, 1024, '0);
      send(ffpa_pkg::OP_ALLOC, 1, '0);
      send(ffpa_pkg::OP_FREE, 0, 48'd5);
      send(ffpa_pkg::OP_FREE, 1024, '0);
      send(ffpa_pkg::OP_FREE, 1024, '0);          // counts saturate
      send(ffpa_pkg::OP_FREE, 1025, '0);
      send(ffpa_pkg::OP_FREE, 1, 48'd1024 * PAGE_BYTES);
      // small region: fragment it so no run fits
      csr_write(ffpa_pkg::REG_PAGES, 64'd8);
      repeat (4) send(ffpa_pkg::OP_ALLOC, 2, '0);
      send(ffpa_pkg::OP_FREE, 2, 48'd1 * PAGE_BYTES);
      send(ffpa_pkg::OP_FREE, 1, 48'd5 * PAGE_BYTES);
      send(ffpa_pkg::OP_ALLOC, 3, '0);
      send(ffpa_pkg::OP_ALLOC, 2, '0);
      // base near the top of the address space: result address wraps
      csr_write(ffpa_pkg::REG_BASE, 64'hFFFF_FFFF_F000);
      csr_write(ffpa_pkg::REG_PAGES, 64'd4);
      send(ffpa_pkg::OP_ALLOC, 1, '0);
      send(ffpa_pkg::OP_ALLOC, 1, '0);
      send(ffpa_pkg::OP_FREE, 1, '0);
      send(ffpa_pkg::OP_FREE, 1, 48'hFFFF_FFFF_FFFF);
      csr_write(ffpa_pkg::REG_PAGES, 64'd0);
      send(ffpa_pkg::OP_ALLOC, 1, '0);
      send(ffpa_pkg::OP_FREE, 0, 48'hFFFF_FFFF_F000);

      gaps_on = 1'b1;
      csr_write(ffpa_pkg::REG_BASE, 64'h0000_1234_5000);
      csr_write(ffpa_pkg::REG_PAGES, 64'd2047);
      random_requests(250);
      csr_write(ffpa_pkg::REG_BASE, {16'h0, rand_addr()});
      csr_write(ffpa_pkg::REG_PAGES, 64'd1);
      random_requests(60);
      csr_write(ffpa_pkg::REG_BASE, 64'hFFFF_FFF0_0000);
      csr_write(ffpa_pkg::REG_PAGES, 64'd37);
      random_requests(200);
      csr_write(ffpa_pkg::REG_PAGES, 64'd0);
      random_requests(20);
      csr_write(ffpa_pkg::REG_BASE, {16'h0, rand_addr()});
      csr_write(ffpa_pkg::REG_PAGES, 64'd200);
      random_requests(250);
      drain();
      gaps_on = 1'b0;
      csr_write(ffpa_pkg::REG_BASE, 64'd0);
      csr_write(ffpa_pkg::REG_PAGES, 64'd1024);
      random_requests(350);

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
